### src/aph_pkg.sv
// Shared types and constants for the autoscale peak hold tracker.
// Used by aph_track, aph_limit and autoscale_peak_hold_tracker.
`default_nettype none

package aph_pkg;

  localparam int DATA_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    POL_FULL   = 2'd0,
    POL_DECAY  = 2'd1,
    POL_HOLD   = 2'd2,
    POL_FROZEN = 2'd3
  } policy_t;

  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_POLICY  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_WEIGHT = 8'd1;

  localparam policy_t POLICY_RESET = POL_DECAY;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd66;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] held_max;
    logic signed [DATA_W-1:0] held_min;
    logic signed [DATA_W-1:0] frame_max;
    logic signed [DATA_W-1:0] frame_min;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] fmax;
    logic signed [DATA_W-1:0] fmin;
  } frame_t;

endpackage

`default_nettype wire

### src/aph_track.sv
// Input register and running frame extremes; hands a frame word on at frame end.
// Depends on aph_pkg.
`default_nettype none

module aph_track (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  smp_valid,
  output logic                 smp_ready,
  input  wire aph_pkg::sample_t smp,
  output logic                 frm_valid,
  input  wire                  frm_ready,
  output aph_pkg::frame_t      frm
);

  logic                                 s1_valid;
  aph_pkg::sample_t                     s1;
  logic signed [aph_pkg::DATA_W-1:0]    running_max;
  logic signed [aph_pkg::DATA_W-1:0]    running_min;
  logic signed [aph_pkg::DATA_W-1:0]    max_next;
  logic signed [aph_pkg::DATA_W-1:0]    min_next;
  logic                                 frm_free;
  logic                                 s1_go;

  assign max_next = (s1.sample > running_max) ? s1.sample : running_max;
  assign min_next = (s1.sample < running_min) ? s1.sample : running_min;

  assign frm_free  = !frm_valid || frm_ready;
  assign s1_go     = s1_valid && (!s1.last || frm_free);
  assign smp_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (smp_ready) begin
      s1_valid <= smp_valid;
    end
    if (smp_ready && smp_valid) begin
      s1 <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= aph_pkg::MOST_NEG;
      running_min <= aph_pkg::MOST_POS;
    end else if (s1_go) begin
      if (s1.last) begin
        running_max <= aph_pkg::MOST_NEG;
        running_min <= aph_pkg::MOST_POS;
      end else begin
        running_max <= max_next;
        running_min <= min_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (frm_free) begin
      frm_valid <= s1_go && s1.last;
    end
    if (frm_free && s1_go && s1.last) begin
      frm.fmax <= max_next;
      frm.fmin <= min_next;
    end
  end

endmodule

`default_nettype wire

### src/aph_limit.sv
// Held limit update per policy and the result register.
// Depends on aph_pkg.
`default_nettype none

module aph_limit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire aph_pkg::policy_t            policy,
  input  wire [aph_pkg::WEIGHT_W-1:0]      weight,
  input  wire                              frm_valid,
  output logic                             frm_ready,
  input  wire aph_pkg::frame_t             frm,
  output logic                             res_valid,
  input  wire                              res_ready,
  output aph_pkg::result_t                 res
);

  localparam int DIFF_W = aph_pkg::DATA_W + 1;
  localparam int PROD_W = DIFF_W + aph_pkg::WEIGHT_W + 1;

  logic signed [aph_pkg::DATA_W-1:0]     limit_high;
  logic signed [aph_pkg::DATA_W-1:0]     limit_low;
  logic signed [aph_pkg::DATA_W-1:0]     limit_high_next;
  logic signed [aph_pkg::DATA_W-1:0]     limit_low_next;
  logic signed [aph_pkg::DATA_W-1:0]     high_decay;
  logic signed [aph_pkg::DATA_W-1:0]     low_decay;
  logic signed [DIFF_W-1:0]              diff_high;
  logic signed [DIFF_W-1:0]              diff_low;
  logic signed [aph_pkg::WEIGHT_W:0]     weight_s;
  logic signed [PROD_W-1:0]              prod_high;
  logic signed [PROD_W-1:0]              prod_low;
  logic signed [PROD_W-1:0]              step_high;
  logic signed [PROD_W-1:0]              step_low;
  logic                                  take;

  assign weight_s  = $signed({1'b0, weight});
  assign diff_high = DIFF_W'(frm.fmax) - DIFF_W'(limit_high);
  assign diff_low  = DIFF_W'(frm.fmin) - DIFF_W'(limit_low);
  assign prod_high = PROD_W'(diff_high) * PROD_W'(weight_s);
  assign prod_low  = PROD_W'(diff_low) * PROD_W'(weight_s);
  assign step_high = prod_high >>> aph_pkg::WEIGHT_W;
  assign step_low  = prod_low >>> aph_pkg::WEIGHT_W;
  assign high_decay = limit_high + step_high[aph_pkg::DATA_W-1:0];
  assign low_decay  = limit_low + step_low[aph_pkg::DATA_W-1:0];

  always_comb begin
    limit_high_next = limit_high;
    limit_low_next  = limit_low;
    case (policy)
      aph_pkg::POL_FULL: begin
        limit_high_next = frm.fmax;
        limit_low_next  = frm.fmin;
      end
      aph_pkg::POL_DECAY: begin
        limit_high_next = (frm.fmax > limit_high) ? frm.fmax : high_decay;
        limit_low_next  = (frm.fmin < limit_low) ? frm.fmin : low_decay;
      end
      aph_pkg::POL_HOLD: begin
        if (frm.fmax > limit_high) limit_high_next = frm.fmax;
        if (frm.fmin < limit_low) limit_low_next = frm.fmin;
      end
      default: begin
      end
    endcase
  end

  assign frm_ready = !res_valid || res_ready;
  assign take      = frm_valid && frm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      limit_high <= aph_pkg::MOST_NEG;
      limit_low  <= aph_pkg::MOST_POS;
    end else begin
      if (frm_ready) res_valid <= frm_valid;
      if (take) begin
        limit_high <= limit_high_next;
        limit_low  <= limit_low_next;
      end
    end
    if (take) begin
      res.held_max  <= limit_high_next;
      res.held_min  <= limit_low_next;
      res.frame_max <= frm.fmax;
      res.frame_min <= frm.fmin;
    end
  end

endmodule

`default_nettype wire

### src/autoscale_peak_hold_tracker.sv
// Top level of the autoscale peak hold tracker: config registers and pipeline.
// Depends on aph_pkg, aph_track and aph_limit.
//
// Usage:
//   smp channel (smp_valid/smp_ready/smp) takes one sample word per cycle
//   when smp_ready is high; smp.last marks the final sample of its frame.
//   res channel (res_valid/res_ready/res) returns one word per frame with the
//   held limits after the frame update and the frame max and min.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes hold_policy
//   (index 0) and decay_weight (index 1); cfg_ready is always high and other
//   indexes are dropped. Write only while no frame is in flight.
// Path: the result word passes the input register, frame register and
//   result register after the edge that accepts the last sample of a frame.
// Throughput: one sample per cycle unless stalled; frames of one sample too.
// Reset clears the pipeline, running extremes and held limits (opposite
//   extremes, so the first frame sets them) and loads policy 1, weight 66.
// When res_ready is low the result word holds; samples keep flowing until
//   a second frame end backs up the frame register, then smp_ready drops.
`default_nettype none

module autoscale_peak_hold_tracker (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  smp_valid,
  output logic                                 smp_ready,
  input  wire aph_pkg::sample_t                smp,
  output logic                                 res_valid,
  input  wire                                  res_ready,
  output aph_pkg::result_t                     res,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [aph_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [aph_pkg::CFG_DATA_W-1:0]        cfg_data
);

  aph_pkg::policy_t                  hold_policy;
  logic [aph_pkg::WEIGHT_W-1:0]      decay_weight;
  logic                              frm_valid;
  logic                              frm_ready;
  aph_pkg::frame_t                   frm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_policy  <= aph_pkg::POLICY_RESET;
      decay_weight <= aph_pkg::WEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == aph_pkg::REG_HOLD_POLICY) begin
        hold_policy <= aph_pkg::policy_t'(cfg_data[1:0]);
      end else if (cfg_index == aph_pkg::REG_DECAY_WEIGHT) begin
        decay_weight <= cfg_data[aph_pkg::WEIGHT_W-1:0];
      end
    end
  end

  aph_track u_track (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp       (smp),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  aph_limit u_limit (
    .clk       (clk),
    .rst       (rst),
    .policy    (hold_policy),
    .weight    (decay_weight),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  a_frame_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.frame_max >= res.frame_min)
    else $error("frame max below frame min");

  a_full_policy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && hold_policy == aph_pkg::POL_FULL) |->
      (res.held_max == res.frame_max && res.held_min == res.frame_min))
    else $error("full policy held limits differ from frame limits");

  a_hold_bounds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (hold_policy == aph_pkg::POL_DECAY ||
                   hold_policy == aph_pkg::POL_HOLD)) |->
      (res.held_max >= res.frame_max && res.held_min <= res.frame_min))
    else $error("held limits inside frame limits");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !smp_ready |-> (res_valid && !res_ready && frm_valid))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

### tb/aph_limit_checker.sv
// Checker for the autoscale peak hold tracker: watches the sample, config and result channels,
// predicts the held and frame limits of each frame and compares them with the result words.
// Depends on aph_pkg.
`default_nettype none

module aph_limit_checker
  import aph_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    smp_valid,
  input  wire                    smp_ready,
  input  wire sample_t           smp,
  input  wire                    res_valid,
  input  wire                    res_ready,
  input  wire result_t           res,
  input  wire                    cfg_valid,
  input  wire                    cfg_ready,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DATA_W-1:0] run_hi;
  logic signed [DATA_W-1:0] run_lo;
  logic signed [DATA_W-1:0] held_hi;
  logic signed [DATA_W-1:0] held_lo;
  policy_t                  policy;
  logic [WEIGHT_W-1:0]      weight;
  result_t                  limits_q[$];

  function automatic logic signed [DATA_W-1:0] decay_step(logic signed [DATA_W-1:0] held,
                                                          logic signed [DATA_W-1:0] target,
                                                          logic [WEIGHT_W-1:0] w);
    longint d;
    longint step;
    d = longint'(target) - longint'(held);
    step = (d * longint'(w)) >>> 16;
    return held + step[DATA_W-1:0];
  endfunction

  task automatic check_field(string name, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t                  want;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] fmax;
    logic signed [DATA_W-1:0] fmin;
    if (rst) begin
      run_hi = MOST_NEG;
      run_lo = MOST_POS;
      held_hi = MOST_NEG;
      held_lo = MOST_POS;
      policy = POLICY_RESET;
      weight = WEIGHT_RESET;
      limits_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD_POLICY:  policy = policy_t'(cfg_data[1:0]);
          REG_DECAY_WEIGHT: weight = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (smp_valid && smp_ready) begin
        s = smp.sample;
        if (s > run_hi) run_hi = s;
        if (s < run_lo) run_lo = s;
        if (smp.last) begin
          fmax = run_hi;
          fmin = run_lo;
          case (policy)
            POL_FULL: begin
              held_hi = fmax;
              held_lo = fmin;
            end
            POL_DECAY: begin
              held_hi = (fmax > held_hi) ? fmax : decay_step(held_hi, fmax, weight);
              held_lo = (fmin < held_lo) ? fmin : decay_step(held_lo, fmin, weight);
            end
            POL_HOLD: begin
              if (fmax > held_hi) held_hi = fmax;
              if (fmin < held_lo) held_lo = fmin;
            end
            default: ;
          endcase
          want.held_max = held_hi;
          want.held_min = held_lo;
          want.frame_max = fmax;
          want.frame_min = fmin;
          limits_q.push_back(want);
          run_hi = MOST_NEG;
          run_lo = MOST_POS;
        end
      end
      if (res_valid && res_ready) begin
        if (limits_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: held %0d/%0d frame %0d/%0d",
                     res.held_max, res.held_min, res.frame_max, res.frame_min);
          mismatches++;
        end else begin
          want = limits_q.pop_front();
          check_field("held_max", want.held_max, res.held_max);
          check_field("held_min", want.held_min, res.held_min);
          check_field("frame_max", want.frame_max, res.frame_max);
          check_field("frame_min", want.frame_min, res.frame_min);
        end
      end
    end
    outstanding = limits_q.size();
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench top for the autoscale peak hold tracker: clock, reset, sample and config stimulus.
// Instantiates autoscale_peak_hold_tracker and aph_limit_checker; depends on aph_pkg.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aph_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd5;
  localparam int IDLE_PCT = 34;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASE_ITEMS = 150;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   smp_valid = 1'b0;
  logic                   smp_ready;
  sample_t                smp = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  result_t                res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   calm = 1'b0;
  int                     mismatches;
  int                     outstanding;

  autoscale_peak_hold_tracker u_dut (.*);

  aph_limit_checker u_checker (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #800us;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  task automatic put_sample(logic signed [DATA_W-1:0] s, logic l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      smp_valid <= 1'b0;
      @(posedge clk);
    end
    smp_valid <= 1'b1;
    smp.sample <= s;
    smp.last <= l;
    do @(posedge clk); while (!smp_ready);
  endtask

  task automatic put_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold until every frame result is back, then let the pipeline empty
  task automatic settle();
    smp_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] pol_word, logic [WEIGHT_W-1:0] w);
    settle();
    put_cfg(REG_HOLD_POLICY, pol_word);
    put_cfg(REG_DECAY_WEIGHT, w);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample(int base);
    int r;
    r = $urandom_range(99);
    if (r < 45) return base + int'($urandom_range(4000)) - 2000;
    if (r < 85) return $urandom;
    case ($urandom_range(3))
      0: return MOST_POS;
      1: return MOST_NEG;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  initial begin
    int sent;
    int phase_end;
    int phase;
    int len;
    int base;
    int r;
    logic [WEIGHT_W-1:0] w;
    policy_t pol;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first frame after reset under the default decay policy
    put_sample(100, 1'b0);
    put_sample(-50, 1'b0);
    put_sample(7, 1'b1);
    put_sample(MOST_POS, 1'b1);
    put_sample(MOST_NEG, 1'b0);
    put_sample(MOST_POS, 1'b1);
    put_sample(0, 1'b1);

    settle();
    put_cfg(REG_HOLD_POLICY, {14'd0, POL_FULL});
    put_cfg(REG_DECAY_WEIGHT, 16'hFFFF);
    put_cfg(REG_SPARE, 16'hFFFF);
    cfg_valid <= 1'b0;
    put_sample(-1, 1'b0);
    put_sample(1, 1'b1);
    put_sample(5, 1'b1);

    configure({14'd0, POL_HOLD}, 16'hFFFF);
    put_sample(3, 1'b0);
    put_sample(-3, 1'b1);
    put_sample(1000, 1'b0);
    put_sample(-1000, 1'b1);

    configure({14'd0, POL_FROZEN}, 16'd0);
    put_sample(MOST_POS, 1'b0);
    put_sample(MOST_NEG, 1'b1);

    // upper policy bits are ignored
    configure({14'h3FFF, POL_DECAY}, 16'd0);
    put_sample(10, 1'b1);
    put_sample(-20, 1'b1);

    configure({14'd0, POL_DECAY}, 16'hFFFF);
    put_sample(50, 1'b1);
    put_sample(MOST_NEG, 1'b1);

    sent = 0;
    phase = 0;
    base = 0;
    while (sent < RANDOM_ITEMS) begin
      pol = policy_t'(phase % 4);
      case (phase % 5)
        0: w = 16'd0;
        1: w = 16'hFFFF;
        2: w = WEIGHT_RESET;
        3: w = 16'd1;
        default: w = 16'($urandom);
      endcase
      configure({14'($urandom), pol}, w);
      calm <= (phase == 5);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(6, 1);
        else if (r < 96) len = $urandom_range(30, 7);
        else len = $urandom_range(120, 31);
        if ($urandom_range(9) == 0) base = $urandom;
        else base += int'($urandom_range(400)) - 200;
        for (int k = 1; k <= len; k++) put_sample(pick_sample(base), k == len);
        sent += len;
        if ($urandom_range(99) < 3) settle();
      end
      phase++;
    end
    calm <= 1'b0;

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
